/* src/sfp_pkg.sv */
package sfp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_LEN     = 4'd1,
    PH_SEQ     = 4'd2,
    PH_SYS     = 4'd3,
    PH_COMP    = 4'd4,
    PH_MSG     = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRC_LO  = 4'd7,
    PH_CRC_HI  = 4'd8
  } phase_t;

  typedef logic [1:0] frame_code_t;

  localparam frame_code_t STATUS_INCOMPLETE = 2'd0;
  localparam frame_code_t STATUS_GOOD       = 2'd1;
  localparam frame_code_t STATUS_BAD_CRC    = 2'd2;
  localparam frame_code_t STATUS_REJECTED   = 2'd3;

  localparam logic REG_START_BYTE  = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam logic [7:0]  START_BYTE_RESET  = 8'd254;
  localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd255;
  localparam logic [15:0] CRC_SEED          = 16'hFFFF;

  // X.25 / MCRF4XX byte update
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ acc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* src/serial_frame_parser_crc16_core.sv */
// Serial frame parser with CRC-16 MCRF4XX check.
// Input channel: in_valid / in_ready carry one received byte (rx_byte) per request.
// Output channel: out_valid / out_ready carry one result per input byte: frame
// status, payload byte with its index, the header fields held so far and the
// error and overrun counters.
// Configuration: cfg_write with cfg_index 0 sets the start byte, index 1 the
// largest accepted payload length; write only while the block is idle.
// Path: a byte lands in the input register at its accept edge, and its result
// moves from there into the result register, which raises out_valid.
// Throughput: one byte per cycle while out_ready is high; the CRC update and
// phase step are one combinational pass from the input to the result register.
// Stall: while out_ready is low the result holds, and one more byte can be taken
// into the input register before in_ready drops.
// Reset (rst, synchronous): parser hunts for the start byte, CRC 0xFFFF, header
// fields and counters zero, start byte 254, payload limit 255, both stages empty.
module serial_frame_parser_crc16_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] frame_status,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] frame_length,
  output logic [7:0] sequence_res,
  output logic [7:0] system_id,
  output logic [7:0] component_id,
  output logic [7:0] message_id,
  output logic [7:0] error_count,
  output logic [7:0] overrun_count,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] start_byte;
  logic [7:0] max_payload;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  sfp_pkg::phase_t phase, phase_next;
  logic        crc_low_bad, crc_low_bad_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  length_reg, length_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  sequence_reg, sequence_next;
  logic [7:0]  system_reg, system_next;
  logic [7:0]  component_reg, component_next;
  logic [7:0]  message_reg, message_next;
  logic [7:0]  error_counter, error_next;
  logic [7:0]  overrun_counter, overrun_next;
  sfp_pkg::frame_code_t status_next;
  logic        pvalid_next;
  logic [7:0]  pbyte_next;
  logic [7:0]  pindex_next;
  logic [15:0] crc_upd;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= sfp_pkg::START_BYTE_RESET;
      max_payload <= sfp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sfp_pkg::REG_START_BYTE:  start_byte  <= cfg_data;
        sfp_pkg::REG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  assign crc_upd = sfp_pkg::crc_step(crc, in_byte);

  always_comb begin
    phase_next       = phase;
    crc_low_bad_next = crc_low_bad;
    crc_next         = crc;
    length_next      = length_reg;
    byte_index_next  = byte_index;
    sequence_next    = sequence_reg;
    system_next      = system_reg;
    component_next   = component_reg;
    message_next     = message_reg;
    error_next       = error_counter;
    overrun_next     = overrun_counter;
    status_next      = sfp_pkg::STATUS_INCOMPLETE;
    pvalid_next      = 1'b0;
    pbyte_next       = 8'd0;
    pindex_next      = 8'd0;
    case (phase)
      sfp_pkg::PH_LEN: begin
        if (in_byte > max_payload) begin
          overrun_next = overrun_counter + 8'd1;
          error_next   = error_counter + 8'd1;
          status_next  = sfp_pkg::STATUS_REJECTED;
          phase_next   = sfp_pkg::PH_IDLE;
        end else begin
          length_next     = in_byte;
          byte_index_next = 8'd0;
          crc_next        = crc_upd;
          phase_next      = sfp_pkg::PH_SEQ;
        end
      end
      sfp_pkg::PH_SEQ: begin
        sequence_next = in_byte;
        crc_next      = crc_upd;
        phase_next    = sfp_pkg::PH_SYS;
      end
      sfp_pkg::PH_SYS: begin
        system_next = in_byte;
        crc_next    = crc_upd;
        phase_next  = sfp_pkg::PH_COMP;
      end
      sfp_pkg::PH_COMP: begin
        component_next = in_byte;
        crc_next       = crc_upd;
        phase_next     = sfp_pkg::PH_MSG;
      end
      sfp_pkg::PH_MSG: begin
        message_next = in_byte;
        crc_next     = crc_upd;
        phase_next   = (length_reg == 8'd0) ? sfp_pkg::PH_CRC_LO : sfp_pkg::PH_PAYLOAD;
      end
      sfp_pkg::PH_PAYLOAD: begin
        pvalid_next     = 1'b1;
        pbyte_next      = in_byte;
        pindex_next     = byte_index;
        byte_index_next = byte_index + 8'd1;
        crc_next        = crc_upd;
        if (byte_index_next == length_reg) begin
          phase_next = sfp_pkg::PH_CRC_LO;
        end
      end
      sfp_pkg::PH_CRC_LO: begin
        crc_low_bad_next = (in_byte != crc[7:0]);
        phase_next       = sfp_pkg::PH_CRC_HI;
      end
      sfp_pkg::PH_CRC_HI: begin
        phase_next       = sfp_pkg::PH_IDLE;
        crc_low_bad_next = 1'b0;
        if (crc_low_bad || (in_byte != crc[15:8])) begin
          status_next = sfp_pkg::STATUS_BAD_CRC;
          error_next  = error_counter + 8'd1;
          if (in_byte == start_byte) begin
            phase_next  = sfp_pkg::PH_LEN;
            length_next = 8'd0;
            crc_next    = sfp_pkg::CRC_SEED;
          end
        end else begin
          status_next = sfp_pkg::STATUS_GOOD;
          error_next  = 8'd0;
        end
      end
      default: begin
        phase_next = sfp_pkg::PH_IDLE;
        if (in_byte == start_byte) begin
          phase_next  = sfp_pkg::PH_LEN;
          length_next = 8'd0;
          crc_next    = sfp_pkg::CRC_SEED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= sfp_pkg::PH_IDLE;
      crc_low_bad     <= 1'b0;
      crc             <= sfp_pkg::CRC_SEED;
      length_reg      <= 8'd0;
      byte_index      <= 8'd0;
      sequence_reg    <= 8'd0;
      system_reg      <= 8'd0;
      component_reg   <= 8'd0;
      message_reg     <= 8'd0;
      error_counter   <= 8'd0;
      overrun_counter <= 8'd0;
    end else if (in_full && advance) begin
      phase           <= phase_next;
      crc_low_bad     <= crc_low_bad_next;
      crc             <= crc_next;
      length_reg      <= length_next;
      byte_index      <= byte_index_next;
      sequence_reg    <= sequence_next;
      system_reg      <= system_next;
      component_reg   <= component_next;
      message_reg     <= message_next;
      error_counter   <= error_next;
      overrun_counter <= overrun_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_full && advance) begin
      frame_status  <= status_next;
      payload_valid <= pvalid_next;
      payload_byte  <= pbyte_next;
      payload_index <= pindex_next;
      frame_length  <= length_next;
      sequence_res  <= sequence_next;
      system_id     <= system_next;
      component_id  <= component_next;
      message_id    <= message_next;
      error_count   <= error_next;
      overrun_count <= overrun_next;
    end
  end

endmodule

/* src/sfp_checker.sv */
module sfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] frame_status,
  input logic       payload_valid,
  input logic [7:0] payload_byte,
  input logic [7:0] payload_index,
  input logic [7:0] error_count
);

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) && $stable(payload_byte)
      && $stable(payload_index) && $stable(error_count))
    else $error("stalled result changed");

  a_payload_incomplete: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> frame_status == sfp_pkg::STATUS_INCOMPLETE)
    else $error("payload byte with a final frame status");

  a_good_clears_errors: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == sfp_pkg::STATUS_GOOD |-> error_count == 8'd0)
    else $error("good frame left errors counted");

  a_idle_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 8'd0)
    else $error("payload fields set on a non-payload byte");

endmodule

bind serial_frame_parser_crc16_core sfp_checker u_sfp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_status (frame_status),
  .payload_valid(payload_valid),
  .payload_byte (payload_byte),
  .payload_index(payload_index),
  .error_count  (error_count)
);
